[sv/hc3_pkg.sv]
// hc3_pkg: types, constants and mod-26 helpers for the 3x3 hill cipher block
// no dependencies; used by every other file of the block
package hc3_pkg;

    localparam int LETTER_W = 5;
    localparam int KEY_W    = 45;
    localparam int KEY_N    = 9;
    localparam int BLOCK_N  = 3;
    localparam int MODULUS  = 26;
    localparam int SUM_W    = 12;

    localparam logic [LETTER_W-1:0] PAD_LETTER = 5'd23;
    localparam int RECIP_MUL = 315;
    localparam int RECIP_SHIFT = 13;

    typedef enum logic [0:0] {
        REG_KEY_LETTERS  = 1'b0,
        REG_DECRYPT_MODE = 1'b1
    } cfg_reg_e;

    typedef logic [LETTER_W-1:0] letter_t;
    typedef logic [KEY_N-1:0][LETTER_W-1:0] matrix_t;

    typedef struct packed {
        matrix_t enc;
        matrix_t dec;
        logic    decrypt;
        logic    not_invertible;
        logic    busy;
    } key_state_t;

    typedef struct packed {
        logic [BLOCK_N-1:0][LETTER_W-1:0] v;
        logic                             msg_end;
    } block_t;

    typedef struct packed {
        logic    ok;
        letter_t val;
    } inv_t;

    // x mod 26 for x below 4096, reciprocal estimate plus one correction
    function automatic letter_t mod26(input logic [SUM_W-1:0] x);
        logic [20:0] prod;
        logic [7:0]  q;
        logic [12:0] r;
        prod = 21'(x) * 21'(RECIP_MUL);
        q    = prod[20:RECIP_SHIFT];
        r    = 13'(x) - 13'(q) * 13'(MODULUS);
        if (r >= 13'(MODULUS))
            r = r - 13'(MODULUS);
        return r[LETTER_W-1:0];
    endfunction

    function automatic letter_t fold_letter(input letter_t x);
        return (x >= letter_t'(MODULUS)) ? letter_t'(x - letter_t'(MODULUS)) : x;
    endfunction

    // modular inverse of units mod 26, 25 with ok low otherwise
    function automatic inv_t inv26(input letter_t d);
        inv_t r;
        r.ok = 1'b1;
        case (d)
            5'd1:    r.val = 5'd1;
            5'd3:    r.val = 5'd9;
            5'd5:    r.val = 5'd21;
            5'd7:    r.val = 5'd15;
            5'd9:    r.val = 5'd3;
            5'd11:   r.val = 5'd19;
            5'd15:   r.val = 5'd7;
            5'd17:   r.val = 5'd23;
            5'd19:   r.val = 5'd11;
            5'd21:   r.val = 5'd5;
            5'd23:   r.val = 5'd17;
            5'd25:   r.val = 5'd25;
            default:
            begin
                r.ok  = 1'b0;
                r.val = 5'd25;
            end
        endcase
        return r;
    endfunction

endpackage

[sv/hc3_if.sv]
// hc3 channel interfaces: letter input, result output and configuration write
// depends on hc3_pkg
interface hc3_in_if;
    logic                           valid;
    logic                           ready;
    logic [hc3_pkg::LETTER_W-1:0]   letter;
    logic                           message_end;

    modport source (output valid, output letter, output message_end, input ready);
    modport sink   (input valid, input letter, input message_end, output ready);
endinterface

interface hc3_out_if;
    logic                           valid;
    logic                           ready;
    logic [hc3_pkg::LETTER_W-1:0]   out_letter;
    logic                           block_last;
    logic                           message_done;
    logic                           key_not_invertible;

    modport source (output valid, output out_letter, output block_last,
                    output message_done, output key_not_invertible, input ready);
    modport sink   (input valid, input out_letter, input block_last,
                    input message_done, input key_not_invertible, output ready);
endinterface

interface hc3_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [0:0]                     index;
    logic [hc3_pkg::KEY_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/hill_cipher_3x3_block.sv]
// 3x3 hill cipher mod 26: one letter taken per cycle unless stalled, three result letters per
// block of three, one result letter per cycle while results are taken. A block's first result
// passes the gather register, then the product register. Letters flow without stall as long as
// blocks are full and results are taken; a message_end on a short block yields three results
// from fewer letters, so input waits on the one-letter-per-cycle output. A key write makes
// the block busy while its inverse matrix is rebuilt (cofactors, determinant inverse, scaling).
// depends on hc3_pkg, hc3_if, hc3_key_unit, hc3_gather, hc3_matmul
module hill_cipher_3x3_block (
    input  logic      clk,
    input  logic      rst_n,
    hc3_in_if.sink    letters,
    hc3_out_if.source results,
    hc3_cfg_if.sink   cfg
);
    import hc3_pkg::*;

    key_state_t key_state;
    logic       blk_valid;
    logic       blk_take;
    block_t     blk;

    hc3_key_unit u_key (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .key_state (key_state)
    );

    hc3_gather u_gather (
        .clk       (clk),
        .rst_n     (rst_n),
        .letters   (letters),
        .key_busy  (key_state.busy),
        .blk_take  (blk_take),
        .blk_valid (blk_valid),
        .blk       (blk)
    );

    hc3_matmul u_matmul (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_state (key_state),
        .blk_valid (blk_valid),
        .blk       (blk),
        .blk_take  (blk_take),
        .results   (results)
    );

endmodule

[sv/hc3_key_unit.sv]
// hc3_key_unit: configuration registers and the three-step inverse key computation
// depends on hc3_pkg and hc3_cfg_if
module hc3_key_unit (
    input  logic               clk,
    input  logic               rst_n,
    hc3_cfg_if.sink            cfg,
    output hc3_pkg::key_state_t key_state
);
    import hc3_pkg::*;

    matrix_t    key_mat_reg;
    matrix_t    cof_reg;
    matrix_t    inv_reg;
    letter_t    mult_reg;
    logic       ninv_reg;
    logic       mode_reg;
    logic [1:0] cnt_reg;

    matrix_t    key_mat_next;
    matrix_t    cof_next;
    matrix_t    inv_next;
    inv_t       mult_next;
    letter_t    det_next;
    logic       cfg_write;

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    always_comb
    begin
        logic [SUM_W-1:0] p1;
        logic [SUM_W-1:0] p2;
        logic [SUM_W-1:0] det_sum;
        for (int k = 0; k < KEY_N; k++)
            key_mat_next[k] = fold_letter(cfg.data[k*LETTER_W +: LETTER_W]);
        for (int i = 0; i < BLOCK_N; i++)
        begin
            for (int j = 0; j < BLOCK_N; j++)
            begin
                p1 = 12'(key_mat_reg[((j+1)%3)*3 + (i+1)%3])
                   * 12'(key_mat_reg[((j+2)%3)*3 + (i+2)%3]);
                p2 = 12'(key_mat_reg[((j+1)%3)*3 + (i+2)%3])
                   * 12'(key_mat_reg[((j+2)%3)*3 + (i+1)%3]);
                cof_next[i*3 + j] = mod26(p1 + 12'(MODULUS * 25) - p2);
            end
        end
        det_sum = '0;
        for (int i = 0; i < BLOCK_N; i++)
            det_sum = det_sum + 12'(key_mat_reg[i]) * 12'(cof_reg[i*3]);
        det_next  = mod26(det_sum);
        mult_next = inv26(det_next);
        for (int k = 0; k < KEY_N; k++)
            inv_next[k] = mod26(12'(mult_reg) * 12'(cof_reg[k]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_mat_reg <= '0;
            cof_reg     <= '0;
            inv_reg     <= '0;
            mult_reg    <= letter_t'(25);
            ninv_reg    <= 1'b1;
            mode_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg.index)
                    REG_KEY_LETTERS:
                    begin
                        key_mat_reg <= key_mat_next;
                        cnt_reg     <= 2'd3;
                    end
                    REG_DECRYPT_MODE:
                        mode_reg <= cfg.data[0];
                    default: ;
                endcase
            end
            else if (cnt_reg != 2'd0)
            begin
                cnt_reg <= cnt_reg - 2'd1;
                case (cnt_reg)
                    2'd3: cof_reg <= cof_next;
                    2'd2:
                    begin
                        mult_reg <= mult_next.val;
                        ninv_reg <= !mult_next.ok;
                    end
                    default: inv_reg <= inv_next;
                endcase
            end
        end
    end

    assign key_state.enc            = key_mat_reg;
    assign key_state.dec            = inv_reg;
    assign key_state.decrypt        = mode_reg;
    assign key_state.not_invertible = ninv_reg;
    assign key_state.busy           = (cnt_reg != 2'd0);

endmodule

[sv/hc3_gather.sv]
// hc3_gather: collects letters into blocks of three, pads at message end
// depends on hc3_pkg and hc3_in_if
module hc3_gather (
    input  logic                clk,
    input  logic                rst_n,
    hc3_in_if.sink              letters,
    input  logic                key_busy,
    input  logic                blk_take,
    output logic                blk_valid,
    output hc3_pkg::block_t     blk
);
    import hc3_pkg::*;

    letter_t    held_reg [2];
    logic [1:0] count_reg;
    logic       blk_valid_reg;
    block_t     blk_reg;

    letter_t    letter_f;
    logic       accept;
    logic       completes;
    block_t     blk_next;

    assign letters.ready = (!blk_valid_reg || blk_take) && !key_busy;
    assign accept        = letters.valid && letters.ready;
    assign letter_f      = fold_letter(letters.letter);
    assign completes     = letters.message_end || (count_reg == 2'd2);

    always_comb
    begin
        blk_next.msg_end = letters.message_end;
        case (count_reg)
            2'd1:
                blk_next.v = {PAD_LETTER, letter_f, held_reg[0]};
            2'd2:
                blk_next.v = {letter_f, held_reg[1], held_reg[0]};
            default:
                blk_next.v = {PAD_LETTER, PAD_LETTER, letter_f};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            blk_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept && completes)
            begin
                count_reg     <= '0;
                blk_valid_reg <= 1'b1;
            end
            else
            begin
                if (accept)
                    count_reg <= count_reg + 2'd1;
                if (blk_take)
                    blk_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && completes)
            blk_reg <= blk_next;
        if (accept && !completes)
            held_reg[count_reg[0]] <= letter_f;
    end

    assign blk_valid = blk_valid_reg;
    assign blk       = blk_reg;

endmodule

[sv/hc3_matmul.sv]
// hc3_matmul: key or inverse matrix times block mod 26, registered, sent one letter a transaction
// depends on hc3_pkg and hc3_out_if
module hc3_matmul (
    input  logic                   clk,
    input  logic                   rst_n,
    input  hc3_pkg::key_state_t    key_state,
    input  logic                   blk_valid,
    input  hc3_pkg::block_t        blk,
    output logic                   blk_take,
    hc3_out_if.source              results
);
    import hc3_pkg::*;

    letter_t    res_reg [BLOCK_N];
    logic       end_reg;
    logic       ninv_reg;
    logic       valid_reg;
    logic [1:0] idx_reg;

    letter_t    res_next [BLOCK_N];
    matrix_t    m;
    logic       last;
    logic       free;

    assign last     = (idx_reg == 2'(BLOCK_N - 1));
    assign free     = !valid_reg || (last && results.ready);
    assign blk_take = blk_valid && free;
    assign m        = key_state.decrypt ? key_state.dec : key_state.enc;

    always_comb
    begin
        logic [SUM_W-1:0] acc;
        for (int r = 0; r < BLOCK_N; r++)
        begin
            acc = '0;
            for (int c = 0; c < BLOCK_N; c++)
                acc = acc + 12'(m[r*3 + c]) * 12'(blk.v[c]);
            res_next[r] = mod26(acc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            if (blk_take)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= '0;
            end
            else if (valid_reg && results.ready)
            begin
                if (last)
                    valid_reg <= 1'b0;
                else
                    idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (blk_take)
        begin
            res_reg  <= res_next;
            end_reg  <= blk.msg_end;
            ninv_reg <= key_state.not_invertible;
        end
    end

    always_comb
    begin
        case (idx_reg)
            2'd1:    results.out_letter = res_reg[1];
            2'd2:    results.out_letter = res_reg[2];
            default: results.out_letter = res_reg[0];
        endcase
    end

    assign results.valid              = valid_reg;
    assign results.block_last         = last;
    assign results.message_done       = last && end_reg;
    assign results.key_not_invertible = ninv_reg;

endmodule

[sv/hc3_checker.sv]
// hc3_checker: port-level assertions on the result channel, bound to the top level
// depends on hc3_pkg and hill_cipher_3x3_block
module hc3_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             valid,
    input logic             ready,
    input hc3_pkg::letter_t out_letter,
    input logic             block_last,
    input logic             message_done,
    input logic             key_not_invertible
);
    import hc3_pkg::*;

    a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && message_done |-> block_last)
        else $error("message_done without block_last");

    a_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> out_letter < letter_t'(MODULUS))
        else $error("result letter out of range");

    a_block_continues: assert property (@(posedge clk) disable iff (!rst_n)
        valid && ready && !block_last
        |=> valid && key_not_invertible == $past(key_not_invertible))
        else $error("block broken before its last letter");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(out_letter))
        else $error("stalled result changed");

endmodule

bind hill_cipher_3x3_block hc3_checker u_hc3_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .valid              (results.valid),
    .ready              (results.ready),
    .out_letter         (results.out_letter),
    .block_last         (results.block_last),
    .message_done       (results.message_done),
    .key_not_invertible (results.key_not_invertible)
);

[tb/sv/hill_cipher_check_pkg.sv]
// cipher_scoreboard: predicts and checks the result letters of the 3x3 hill cipher block
// keeps its own key matrix, inverse matrix, mode and partial block; depends on hc3_pkg
package hill_cipher_check_pkg;

    import hc3_pkg::*;

    typedef struct {
        letter_t out_letter;
        logic    block_last;
        logic    message_done;
        logic    key_not_invertible;
    } cipher_out_t;

    class cipher_scoreboard;

        int unsigned key_mat [9];
        int unsigned inv_mat [9];
        bit          key_ok;
        bit          decrypting;
        int unsigned held [2];
        int unsigned held_n;
        cipher_out_t expected_letters [$];
        int unsigned mismatches;

        function new();
            decrypting = 1'b0;
            held_n     = 0;
            held[0]    = 0;
            held[1]    = 0;
            mismatches = 0;
            load_key('0);
        endfunction

        function int unsigned wrap26(input int x);
            int m;
            m = x % MODULUS;
            if (m < 0)
                m += MODULUS;
            return m;
        endfunction

        function int entry(input int r, input int c);
            return key_mat[(r % 3) * 3 + (c % 3)];
        endfunction

        // determinant inverse times adjugate, multiplier 25 when no inverse exists
        function void load_key(input logic [KEY_W-1:0] bits);
            int          det;
            int          cof;
            int unsigned d;
            int unsigned mult;
            int          i;
            int          j;
            for (i = 0; i < KEY_N; i++)
                key_mat[i] = bits[5*i +: 5] % MODULUS;
            det = 0;
            for (i = 0; i < 3; i++)
                det += entry(0, i) * (entry(1, i + 1) * entry(2, i + 2)
                                      - entry(1, i + 2) * entry(2, i + 1));
            d      = wrap26(det);
            key_ok = 1'b0;
            mult   = 25;
            for (i = 0; i < MODULUS; i++)
            begin
                if (!key_ok && (d * i) % MODULUS == 1)
                begin
                    mult   = i;
                    key_ok = 1'b1;
                end
            end
            for (i = 0; i < 3; i++)
            begin
                for (j = 0; j < 3; j++)
                begin
                    cof = entry(j + 1, i + 1) * entry(j + 2, i + 2)
                        - entry(j + 1, i + 2) * entry(j + 2, i + 1);
                    inv_mat[i * 3 + j] = (mult * wrap26(cof)) % MODULUS;
                end
            end
        endfunction

        function void write_reg(input cfg_reg_e idx, input logic [KEY_W-1:0] data);
            case (idx)
                REG_KEY_LETTERS:  load_key(data);
                REG_DECRYPT_MODE: decrypting = data[0];
                default:          ;
            endcase
        endfunction

        function void note_letter(input letter_t raw, input logic msg_end);
            int unsigned v [3];
            int unsigned n;
            int unsigned r;
            int unsigned c;
            int unsigned acc;
            int unsigned l;
            cipher_out_t o;
            l = raw % MODULUS;
            if (held_n + 1 < BLOCK_N && !msg_end)
            begin
                held[held_n] = l;
                held_n++;
                return;
            end
            for (n = 0; n < held_n; n++)
                v[n] = held[n];
            v[n] = l;
            n++;
            while (n < BLOCK_N)
            begin
                v[n] = PAD_LETTER;
                n++;
            end
            held_n = 0;
            for (r = 0; r < BLOCK_N; r++)
            begin
                acc = 0;
                for (c = 0; c < BLOCK_N; c++)
                    acc += (decrypting ? inv_mat[r * 3 + c] : key_mat[r * 3 + c]) * v[c];
                o.out_letter         = letter_t'(acc % MODULUS);
                o.block_last         = (r == 2);
                o.message_done       = (r == 2) && msg_end;
                o.key_not_invertible = !key_ok;
                expected_letters.push_back(o);
            end
        endfunction

        function void check_letter(input letter_t got, input logic blk_last,
                                   input logic done, input logic bad_key);
            cipher_out_t e;
            if (expected_letters.size() == 0)
            begin
                $error("result letter %0d with no transaction expected", got);
                mismatches++;
                return;
            end
            e = expected_letters.pop_front();
            if (got !== e.out_letter)
            begin
                $error("out_letter: expected %0d, actual %0d", e.out_letter, got);
                mismatches++;
            end
            if (blk_last !== e.block_last)
            begin
                $error("block_last: expected %0b, actual %0b", e.block_last, blk_last);
                mismatches++;
            end
            if (done !== e.message_done)
            begin
                $error("message_done: expected %0b, actual %0b", e.message_done, done);
                mismatches++;
            end
            if (bad_key !== e.key_not_invertible)
            begin
                $error("key_not_invertible: expected %0b, actual %0b",
                       e.key_not_invertible, bad_key);
                mismatches++;
            end
        endfunction

    endclass

endpackage

[tb/sv/hill_cipher_3x3_block_test.sv]
// hill_cipher_3x3_block_test: directed and random letter streams through the cipher block
// under changing keys, modes and back-pressure; depends on hc3_pkg, hc3_if,
// hill_cipher_check_pkg and the block's RTL
module hill_cipher_3x3_block_test;

    timeunit 1ns;
    timeprecision 1ps;

    import hc3_pkg::*;
    import hill_cipher_check_pkg::*;

    logic clk;
    logic rst_n;

    hc3_in_if  letters_ch ();
    hc3_out_if results_ch ();
    hc3_cfg_if cfg_ch ();

    hill_cipher_3x3_block DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .letters (letters_ch),
        .results (results_ch),
        .cfg     (cfg_ch)
    );

    cipher_scoreboard sb = new();

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned hold_requests;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #500000;
        $display("TEST FAILED");
        $finish;
    end

    // receiver: random stalls plus an occasional long hold-off
    initial
    begin
        int unsigned hold_seen;
        int unsigned hold_left;
        hold_seen = 0;
        hold_left = 0;
        results_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_requests)
            begin
                hold_seen = hold_requests;
                hold_left = 80;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                results_ch.ready <= 1'b0;
            end
            else
                results_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (letters_ch.valid && letters_ch.ready)
                sb.note_letter(letters_ch.letter, letters_ch.message_end);
            if (results_ch.valid && results_ch.ready)
                sb.check_letter(results_ch.out_letter, results_ch.block_last,
                                results_ch.message_done, results_ch.key_not_invertible);
            if (cfg_ch.valid && cfg_ch.ready)
                sb.write_reg(cfg_reg_e'(cfg_ch.index), cfg_ch.data);
        end
    end

    function automatic letter_t random_letter();
        if ($urandom_range(9) == 0)
            return letter_t'($urandom_range(31, 26));
        return letter_t'($urandom_range(25));
    endfunction

    function automatic logic [KEY_W-1:0] random_key();
        logic [KEY_W-1:0] k;
        int               i;
        k = '0;
        case ($urandom_range(5))
            0:       k = '0;
            1:       k = '1;
            default:
                for (i = 0; i < KEY_N; i++)
                    k[5*i +: 5] = random_letter();
        endcase
        return k;
    endfunction

    task automatic send_letter(input letter_t l, input logic msg_end);
        while ($urandom_range(99) < send_idle_pct)
        begin
            letters_ch.valid <= 1'b0;
            @(posedge clk);
        end
        letters_ch.valid       <= 1'b1;
        letters_ch.letter      <= l;
        letters_ch.message_end <= msg_end;
        @(posedge clk);
        while (!letters_ch.ready)
            @(posedge clk);
    endtask

    // stop offering letters until every pending result letter has come back
    task automatic drain();
        letters_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_letters.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_settings(input bit do_key, input logic [KEY_W-1:0] key,
                                  input bit do_mode, input logic mode);
        if (!do_key && !do_mode)
            return;
        cfg_ch.valid <= 1'b1;
        if (do_key)
        begin
            cfg_ch.index <= REG_KEY_LETTERS;
            cfg_ch.data  <= key;
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
        end
        if (do_mode)
        begin
            cfg_ch.index <= REG_DECRYPT_MODE;
            cfg_ch.data  <= KEY_W'(mode);
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic reconfigure();
        int unsigned pick;
        pick = $urandom_range(3);
        drain();
        write_settings(pick != 1, random_key(), pick != 0, 1'($urandom_range(1)));
    endtask

    task automatic run_phase(input int unsigned n_items, input int unsigned sidle,
                             input int unsigned rstall, input bit hold);
        int unsigned sent;
        int unsigned len;
        int unsigned k;
        send_idle_pct  = sidle;
        recv_stall_pct = rstall;
        reconfigure();
        if (hold)
            hold_requests++;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(7) == 0)
                reconfigure();
            len = ($urandom_range(5) == 0) ? $urandom_range(20, 11) : $urandom_range(10, 1);
            for (k = 0; k < len; k++)
                send_letter(random_letter(), k == len - 1);
            sent += len;
        end
        drain();
    endtask

    initial
    begin
        rst_n                  <= 1'b0;
        letters_ch.valid       <= 1'b0;
        letters_ch.letter      <= '0;
        letters_ch.message_end <= 1'b0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.index           <= REG_KEY_LETTERS;
        cfg_ch.data            <= '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests  = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero key after reset, extreme and out-of-range letters
        send_letter(5'd0, 1'b0);
        send_letter(5'd25, 1'b0);
        send_letter(5'd31, 1'b0);
        drain();

        // invertible key, entries listed from 8 down to 0
        write_settings(1'b1, {5'd15, 5'd17, 5'd20, 5'd10, 5'd16, 5'd13, 5'd1, 5'd24, 5'd6},
                       1'b0, 1'b0);
        send_letter(5'd26, 1'b0);
        send_letter(5'd30, 1'b0);
        send_letter(5'd7, 1'b1);
        send_letter(5'd19, 1'b1);
        send_letter(5'd1, 1'b0);
        send_letter(5'd12, 1'b1);
        drain();

        // decrypt, with padding of a short block
        write_settings(1'b0, '0, 1'b1, 1'b1);
        send_letter(5'd15, 1'b0);
        send_letter(5'd8, 1'b0);
        send_letter(5'd3, 1'b0);
        send_letter(5'd22, 1'b1);

        // mode change with one letter held
        send_letter(5'd4, 1'b0);
        drain();
        write_settings(1'b0, '0, 1'b1, 1'b0);
        send_letter(5'd17, 1'b0);
        send_letter(5'd2, 1'b0);

        // key change with two letters held, singular key in decrypt mode
        send_letter(5'd9, 1'b0);
        send_letter(5'd11, 1'b0);
        drain();
        write_settings(1'b1, '1, 1'b1, 1'b1);
        send_letter(5'd24, 1'b1);
        drain();

        run_phase(140, 6, 78, 1'b1);
        run_phase(140, 78, 6, 1'b0);
        run_phase(140, 0, 0, 1'b1);

        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_letters.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
